>>> rtl/core/qisd_pkg.sv
package qisd_pkg;

  // Default depth of the quadrant digit stack (largest supported image side log2)
  localparam int MAX_LOG2_DEF = 12;

  // Field widths
  localparam int BYTE_W   = 8;
  localparam int CORNER_W = 12;
  localparam int SQ_W     = 4;
  localparam int CFG_W    = 4;

  // Configuration port
  localparam int APB_AW = 3;
  localparam int APB_DW = 32;
  localparam int REG_IDX_W = APB_AW - 2;
  localparam logic [REG_IDX_W-1:0] REG_SIZE_LOG2 = '0;
  localparam logic [CFG_W-1:0] SIZE_LOG2_RST = 4'd8;

  // Stream codes
  localparam logic [BYTE_W-1:0] TAG_LEAF  = 8'd0;
  localparam logic [BYTE_W-1:0] TAG_SPLIT = 8'd1;
  localparam logic [1:0]        QUAD_LAST = 2'd3;

  typedef enum logic [1:0] {
    PH_TAG,
    PH_RED,
    PH_GREEN,
    PH_BLUE
  } phase_e;

  typedef struct packed {
    logic [CORNER_W-1:0] corner_x;
    logic [CORNER_W-1:0] corner_y;
    logic [SQ_W-1:0]     square_log2;
    logic [BYTE_W-1:0]   red;
    logic [BYTE_W-1:0]   green;
    logic [BYTE_W-1:0]   blue;
    logic                image_done;
    logic                bad_node;
  } fill_t;

endpackage

>>> rtl/core/qisd_cfg.sv
module qisd_cfg #(
  parameter int MAX_LOG2 = qisd_pkg::MAX_LOG2_DEF,
  localparam int DW = $clog2(MAX_LOG2 + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [qisd_pkg::APB_AW-1:0] paddr,
  input  logic [qisd_pkg::APB_DW-1:0] pwdata,
  output logic [qisd_pkg::APB_DW-1:0] prdata,
  output logic                        pready,
  output logic [DW-1:0]               eff_size_o,
  output logic                        restart_o
);
  import qisd_pkg::*;

  logic [CFG_W-1:0] size_log2_q, size_log2_d;
  logic             hit;

  assign hit       = (paddr[APB_AW-1:2] == REG_SIZE_LOG2);
  assign pready    = 1'b1;
  assign restart_o = psel && penable && pwrite && hit;

  always_comb begin
    size_log2_d = size_log2_q;
    if (restart_o) begin
      size_log2_d = pwdata[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_log2_q <= SIZE_LOG2_RST;
    end else begin
      size_log2_q <= size_log2_d;
    end
  end

  assign prdata = hit ? APB_DW'(size_log2_q) : '0;

  // Saturate the image size at the digit stack depth
  always_comb begin
    if (int'(size_log2_q) > MAX_LOG2) begin
      eff_size_o = DW'(MAX_LOG2);
    end else begin
      eff_size_o = DW'(size_log2_q);
    end
  end

endmodule

>>> rtl/core/qisd_walker.sv
module qisd_walker #(
  parameter int MAX_LOG2 = qisd_pkg::MAX_LOG2_DEF,
  localparam int DW = $clog2(MAX_LOG2 + 1)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        restart_i,
  input  logic [DW-1:0]               eff_size_i,
  input  logic                        accept_i,
  input  logic [qisd_pkg::BYTE_W-1:0] data_byte_i,
  output logic                        fill_valid_o,
  output qisd_pkg::fill_t             fill_o
);
  import qisd_pkg::*;

  phase_e              phase_q, phase_d;
  logic [DW-1:0]       depth_q, depth_d;
  logic [1:0]          dig_q [MAX_LOG2];
  logic [1:0]          dig_d [MAX_LOG2];
  logic [1:0]          adv_dig [MAX_LOG2];
  logic [BYTE_W-1:0]   red_q, red_d, green_q, green_d;
  logic                finished_q, finished_d;
  logic [MAX_LOG2-1:0] pos_x, pos_y;
  logic [DW-1:0]       adv_depth;
  logic                adv_done;
  logic                take_adv;

  // Corner of the current node: digit at level i weighs 2^(size - i)
  always_comb begin
    pos_x = '0;
    pos_y = '0;
    for (int k = 0; k < MAX_LOG2; k++) begin
      if (depth_q > DW'(k)) begin
        pos_x = pos_x | (MAX_LOG2'(dig_q[k][0]) << (eff_size_i - DW'(k + 1)));
        pos_y = pos_y | (MAX_LOG2'(dig_q[k][1]) << (eff_size_i - DW'(k + 1)));
      end
    end
  end

  // Next node in preorder: deepest level whose digit can still step
  always_comb begin
    adv_depth = '0;
    for (int k = 0; k < MAX_LOG2; k++) begin
      if (depth_q > DW'(k) && dig_q[k] != QUAD_LAST) begin
        adv_depth = DW'(k + 1);
      end
    end
    adv_done = (adv_depth == '0);
    for (int k = 0; k < MAX_LOG2; k++) begin
      adv_dig[k] = dig_q[k];
      if (DW'(k + 1) == adv_depth) begin
        adv_dig[k] = dig_q[k] + 2'd1;
      end else if (DW'(k) >= adv_depth && depth_q > DW'(k)) begin
        adv_dig[k] = '0;
      end
    end
  end

  always_comb begin
    phase_d    = phase_q;
    depth_d    = depth_q;
    dig_d      = dig_q;
    red_d      = red_q;
    green_d    = green_q;
    finished_d = finished_q;
    take_adv   = 1'b0;

    fill_valid_o       = 1'b0;
    fill_o.corner_x    = CORNER_W'(pos_x);
    fill_o.corner_y    = CORNER_W'(pos_y);
    fill_o.square_log2 = SQ_W'(eff_size_i - depth_q);
    fill_o.red         = '0;
    fill_o.green       = '0;
    fill_o.blue        = '0;
    fill_o.image_done  = 1'b0;
    fill_o.bad_node    = 1'b0;

    if (restart_i) begin
      phase_d    = PH_TAG;
      depth_d    = '0;
      red_d      = '0;
      green_d    = '0;
      finished_d = 1'b0;
      for (int k = 0; k < MAX_LOG2; k++) begin
        dig_d[k] = '0;
      end
    end else if (accept_i && !finished_q) begin
      unique case (phase_q)
        PH_TAG: begin
          priority if (data_byte_i == TAG_LEAF) begin
            phase_d = PH_RED;
          end else if (data_byte_i == TAG_SPLIT && depth_q < eff_size_i) begin
            depth_d = depth_q + DW'(1);
            for (int k = 0; k < MAX_LOG2; k++) begin
              if (DW'(k) == depth_q) begin
                dig_d[k] = '0;
              end
            end
          end else begin
            fill_valid_o    = 1'b1;
            fill_o.bad_node = 1'b1;
            take_adv        = 1'b1;
          end
        end
        PH_RED: begin
          red_d   = data_byte_i;
          phase_d = PH_GREEN;
        end
        PH_GREEN: begin
          green_d = data_byte_i;
          phase_d = PH_BLUE;
        end
        PH_BLUE: begin
          fill_valid_o = 1'b1;
          fill_o.red   = red_q;
          fill_o.green = green_q;
          fill_o.blue  = data_byte_i;
          phase_d      = PH_TAG;
          take_adv     = 1'b1;
        end
        default: begin
          phase_d = PH_TAG;
        end
      endcase
      if (take_adv) begin
        dig_d             = adv_dig;
        depth_d           = adv_depth;
        finished_d        = adv_done;
        fill_o.image_done = adv_done;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q    <= PH_TAG;
      depth_q    <= '0;
      red_q      <= '0;
      green_q    <= '0;
      finished_q <= 1'b0;
      for (int k = 0; k < MAX_LOG2; k++) begin
        dig_q[k] <= '0;
      end
    end else begin
      phase_q    <= phase_d;
      depth_q    <= depth_d;
      red_q      <= red_d;
      green_q    <= green_d;
      finished_q <= finished_d;
      dig_q      <= dig_d;
    end
  end

endmodule

>>> rtl/core/qisd_out_stage.sv
module qisd_out_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            load_i,
  input  logic            fill_valid_i,
  input  qisd_pkg::fill_t fill_i,
  input  logic            out_stall_i,
  output logic            out_valid_o,
  output logic            full_stall_o,
  output qisd_pkg::fill_t fill_o
);
  import qisd_pkg::*;

  logic  valid_q, valid_d;
  fill_t fill_q, fill_d;

  // Hold back new requests only while a result sits here and is not taken
  assign full_stall_o = valid_q && out_stall_i;

  always_comb begin
    valid_d = valid_q;
    fill_d  = fill_q;
    if (load_i) begin
      valid_d = fill_valid_i;
      fill_d  = fill_i;
    end else if (!out_stall_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    fill_q <= fill_d;
  end

  assign out_valid_o = valid_q;
  assign fill_o      = fill_q;

endmodule

>>> rtl/core/quadtree_image_stream_decoder.sv
// Channel   Direction  Handshake                Payload
// --------  ---------  -----------------------  ---------------------------------------------
// input     in         in_valid_i / in_stall_o  data_byte_i
// output    out        out_valid_o/out_stall_i  corner_x_o corner_y_o square_log2_o red_o
//                                               green_o blue_o image_done_o bad_node_o
// config    in         APB psel/penable/pwrite  size_log2 at byte address 0
//
// One byte per cycle while in_stall_o is low: the walker updates phase, depth and
// quadrant digits in the cycle a request is taken, and a fill lands in the output register
// at that same edge; it is visible in the cycle after its blue byte (or bad tag) is taken.
// Reset returns to the first tag with size_log2 = 8; no clearing pass is needed.
// in_stall_o rises only while the output register holds a fill and out_stall_i is high.
// A size_log2 write restarts the tree walk.
module quadtree_image_stream_decoder #(
  parameter int MAX_LOG2 = qisd_pkg::MAX_LOG2_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [qisd_pkg::BYTE_W-1:0]   data_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [qisd_pkg::CORNER_W-1:0] corner_x_o,
  output logic [qisd_pkg::CORNER_W-1:0] corner_y_o,
  output logic [qisd_pkg::SQ_W-1:0]     square_log2_o,
  output logic [qisd_pkg::BYTE_W-1:0]   red_o,
  output logic [qisd_pkg::BYTE_W-1:0]   green_o,
  output logic [qisd_pkg::BYTE_W-1:0]   blue_o,
  output logic                          image_done_o,
  output logic                          bad_node_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [qisd_pkg::APB_AW-1:0]   paddr,
  input  logic [qisd_pkg::APB_DW-1:0]   pwdata,
  output logic [qisd_pkg::APB_DW-1:0]   prdata,
  output logic                          pready
);
  import qisd_pkg::*;

  localparam int DW = $clog2(MAX_LOG2 + 1);

  logic          restart;
  logic [DW-1:0] eff_size;
  logic          accept;
  logic          fill_valid;
  fill_t         fill_new;
  fill_t         fill_out;

  // Take a request whenever the output register is free or drains this cycle
  assign accept = in_valid_i && !in_stall_o;

  qisd_cfg #(
    .MAX_LOG2(MAX_LOG2)
  ) u_cfg (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .eff_size_o(eff_size),
    .restart_o (restart)
  );

  // Tree walk: tag / colour phases, depth and quadrant digit stack
  qisd_walker #(
    .MAX_LOG2(MAX_LOG2)
  ) u_walker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .restart_i   (restart),
    .eff_size_i  (eff_size),
    .accept_i    (accept),
    .data_byte_i (data_byte_i),
    .fill_valid_o(fill_valid),
    .fill_o      (fill_new)
  );

  // Output register separates the two handshakes
  qisd_out_stage u_out (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (accept),
    .fill_valid_i(fill_valid),
    .fill_i      (fill_new),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .full_stall_o(in_stall_o),
    .fill_o      (fill_out)
  );

  assign corner_x_o    = fill_out.corner_x;
  assign corner_y_o    = fill_out.corner_y;
  assign square_log2_o = fill_out.square_log2;
  assign red_o         = fill_out.red;
  assign green_o       = fill_out.green;
  assign blue_o        = fill_out.blue;
  assign image_done_o  = fill_out.image_done;
  assign bad_node_o    = fill_out.bad_node;

`ifndef SYNTHESIS
  // Once the last node is delivered, the walk goes quiet
  a_done_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && image_done_o && !out_stall_i |=> !out_valid_o)
    else $error("fill produced after image completion");

  // A bad node never carries a colour
  a_bad_no_colour: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && bad_node_o |-> red_o == '0 && green_o == '0 && blue_o == '0)
    else $error("bad node carries colour");

  // A square never exceeds the image
  a_square_fits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> DW'(square_log2_o) <= eff_size)
    else $error("square larger than image");
`endif

endmodule
